// File: rtl/gcsl_pkg.sv
// ----------------------------------------------------------------------------
// gcsl_pkg
// Shared types and fixed constants of the glyph cache slot lookup block.
// ----------------------------------------------------------------------------
package gcsl_pkg;

    localparam int FACE_W     = 2;
    localparam int KEY_W      = 21;
    localparam int SLOT_OUT_W = 10;
    localparam int STAMP_W    = 32;
    localparam int HASH_W     = 32;

    // Multiplicative (Fibonacci) hash constant
    localparam logic [HASH_W-1:0] HASH_MUL = 32'd2654435761;

    localparam logic [KEY_W-1:0] KEY_EMPTY = '0;

    // One cache entry: code point and last-use stamp
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_PROBE,
        ST_WRITE
    } t_state;

endpackage

// File: rtl/glyph_cache_slot_lookup_core.sv
// ----------------------------------------------------------------------------
// glyph_cache_slot_lookup_core
// Open-addressed glyph cache, one table per face, linear probing, LRU victim.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_face, i_key
//  out     | source    | o_out_valid / i_out_stall  | o_slot, o_hit, o_evicted,
//          |           |                            | o_old_key
//
//  A lookup probes slots on the chain from its home slot; when SLOTS is not a
//  power of two, the home slot remainder is first found by reciprocal multiply.
//  The probe loop reads one entry per cycle from the single entry memory.
//  After reset a clearing pass writes FACES*SLOTS entries, one per cycle
//  (4096 with default parameters); o_in_stall stays high through it.
//  A finished result waits in the output register; the next input beat is
//  taken meanwhile, but its write-back waits until that register frees up.
//
module glyph_cache_slot_lookup_core #(
    parameter int SLOTS = 1024,
    parameter int FACES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [gcsl_pkg::FACE_W-1:0]       i_face,
    input  logic [gcsl_pkg::KEY_W-1:0]        i_key,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gcsl_pkg::SLOT_OUT_W-1:0]   o_slot,
    output logic                              o_hit,
    output logic                              o_evicted,
    output logic [gcsl_pkg::KEY_W-1:0]        o_old_key
);
    import gcsl_pkg::*;

    localparam int  DEPTH   = FACES * SLOTS;
    localparam int  ADDR_W  = $clog2(DEPTH);
    localparam int  SLOT_W  = $clog2(SLOTS);
    localparam int  CNT_W   = $clog2(SLOTS + 1);
    localparam int  FIDX_W  = (FACES > 1) ? $clog2(FACES) : 1;
    localparam bit  IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
    localparam int  PROD_W  = 2 * HASH_W;
    // floor(2^32 / SLOTS): quotient estimate is exact or one short
    localparam logic [HASH_W-1:0] RECIP = HASH_W'(64'h1_0000_0000 / 64'(SLOTS));

    // ------------------------------------------------------------------
    // State and registers
    // ------------------------------------------------------------------
    t_state                 r_state, n_state;

    t_entry                 mem [DEPTH];
    t_entry                 r_rd_q;

    logic [ADDR_W-1:0]      r_clr_addr;
    logic [STAMP_W-1:0]     r_use [FACES];

    logic [KEY_W-1:0]       r_key;
    logic [FIDX_W-1:0]      r_face;
    logic [ADDR_W-1:0]      r_base;
    logic [HASH_W-1:0]      r_hash;
    logic [HASH_W-1:0]      r_quot;
    logic [SLOT_W:0]        r_rem;
    logic [1:0]             r_mod_step;

    // probe pipeline: read issue side and check side
    logic [SLOT_W-1:0]      r_rd_idx;
    logic [CNT_W-1:0]       r_issue_cnt;
    logic                   r_chk_v;
    logic                   r_chk_last;
    logic [SLOT_W-1:0]      r_chk_idx;
    logic                   r_first;

    // running LRU candidate on the chain
    logic [SLOT_W-1:0]      r_victim;
    logic [STAMP_W-1:0]     r_old_stamp;
    logic [KEY_W-1:0]       r_victim_key;

    // decided outcome
    logic [SLOT_W-1:0]      r_tgt;
    logic                   r_tgt_hit;
    logic                   r_tgt_evict;
    logic [KEY_W-1:0]       r_tgt_old_key;

    // output register
    logic                   r_out_valid;
    logic [SLOT_OUT_W-1:0]  r_out_slot;
    logic                   r_out_hit;
    logic                   r_out_evicted;
    logic [KEY_W-1:0]       r_out_old_key;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [FACE_W-1:0]      face_mod;
    logic [PROD_W-1:0]      quot_prod;
    logic [SLOT_W-1:0]      rem_next;
    logic                   clr_last;
    logic                   out_free;
    logic                   chk_hit;
    logic                   chk_empty;
    logic                   chk_full;
    logic                   chk_older;
    logic                   issue;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [STAMP_W-1:0]     stamp_new;
    logic                   mem_we;
    logic                   in_fire;
    logic                   wr_fire;

    // face index modulo FACES: input is below 4, so three conditional subtracts do
    always_comb begin
        face_mod = i_face;
        for (int i = 0; i < 3; i++) begin
            if (int'(face_mod) >= FACES) begin
                face_mod = face_mod - FACE_W'(FACES);
            end
        end
    end

    // home slot remainder: quotient estimate, then hash - q*SLOTS (below
    // 2*SLOTS), then one compare and subtract
    always_comb begin
        quot_prod = PROD_W'(r_hash) * PROD_W'(RECIP);
        if (r_rem >= (SLOT_W + 1)'(SLOTS)) begin
            rem_next = SLOT_W'(r_rem - (SLOT_W + 1)'(SLOTS));
        end else begin
            rem_next = SLOT_W'(r_rem);
        end
    end

    assign clr_last  = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign out_free  = !r_out_valid || !i_out_stall;

    // key match is checked first: key zero hits the first empty slot
    assign chk_hit   = r_chk_v && (r_rd_q.key == r_key);
    assign chk_empty = r_chk_v && !chk_hit && (r_rd_q.key == KEY_EMPTY);
    assign chk_older = r_first || (r_rd_q.stamp < r_old_stamp);
    assign chk_full  = r_chk_v && !chk_hit && !chk_empty && r_chk_last;

    assign issue     = (r_issue_cnt < CNT_W'(SLOTS));
    assign rd_addr   = r_base + ADDR_W'(r_rd_idx);
    assign wr_addr   = r_base + ADDR_W'(r_tgt);
    assign stamp_new = r_use[r_face] + 1'b1;

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_HASH;
            ST_HASH: begin
                if (IS_POW2) n_state = ST_PROBE;
                else         n_state = ST_MOD;
            end
            ST_MOD:   if (r_mod_step == 2'd2) n_state = ST_PROBE;
            ST_PROBE: if (chk_hit || chk_empty || chk_full) n_state = ST_WRITE;
            ST_WRITE: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        in_fire    = 1'b0;
        wr_fire    = 1'b0;
        mem_we     = 1'b0;
        unique case (r_state)
            ST_CLEAR: mem_we = 1'b1;
            ST_IDLE: begin
                o_in_stall = 1'b0;
                in_fire    = i_in_valid;
            end
            ST_WRITE: begin
                wr_fire = out_free;
                mem_we  = out_free;
            end
            ST_HASH, ST_MOD, ST_PROBE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end

    // ------------------------------------------------------------------
    // Entry memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            if (r_state == ST_CLEAR) mem[r_clr_addr] <= '0;
            else                     mem[wr_addr]    <= '{key: r_key, stamp: stamp_new};
        end
        if (r_state == ST_PROBE && issue) begin
            r_rd_q <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < FACES; i++) r_use[i] <= '0;
        end else begin
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (wr_fire) begin
                r_use[r_face] <= stamp_new;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_key  <= i_key;
            r_face <= FIDX_W'(face_mod);
            r_base <= ADDR_W'(32'(face_mod) * SLOTS);
            r_hash <= HASH_W'(i_key * HASH_MUL);
        end

        // home slot, then probe pipeline setup
        if (r_state == ST_HASH) begin
            r_rd_idx    <= r_hash[SLOT_W-1:0];
            r_mod_step  <= '0;
            r_issue_cnt <= '0;
            r_chk_v     <= 1'b0;
            r_first     <= 1'b1;
        end
        if (r_state == ST_MOD) begin
            r_mod_step <= r_mod_step + 1'b1;
            if (r_mod_step == 2'd0) begin
                r_quot <= quot_prod[PROD_W-1:HASH_W];
            end else if (r_mod_step == 2'd1) begin
                r_rem <= (SLOT_W + 1)'(r_hash - HASH_W'(r_quot * HASH_W'(SLOTS)));
            end else begin
                r_rd_idx <= rem_next;
            end
        end

        if (r_state == ST_PROBE) begin
            // issue side: next slot on the chain, wrapping round the table
            r_chk_v <= issue;
            if (issue) begin
                r_chk_idx   <= r_rd_idx;
                r_chk_last  <= (r_issue_cnt == CNT_W'(SLOTS - 1));
                r_issue_cnt <= r_issue_cnt + 1'b1;
                r_rd_idx    <= (r_rd_idx == SLOT_W'(SLOTS - 1)) ? '0 : r_rd_idx + 1'b1;
            end

            // check side
            if (r_chk_v) begin
                r_first <= 1'b0;
                if (chk_older) begin
                    r_victim     <= r_chk_idx;
                    r_old_stamp  <= r_rd_q.stamp;
                    r_victim_key <= r_rd_q.key;
                end
            end

            if (chk_hit || chk_empty) begin
                r_tgt         <= r_chk_idx;
                r_tgt_hit     <= chk_hit;
                r_tgt_evict   <= 1'b0;
                r_tgt_old_key <= '0;
            end else if (chk_full) begin
                r_tgt_hit   <= 1'b0;
                r_tgt_evict <= 1'b1;
                if (chk_older) begin
                    r_tgt         <= r_chk_idx;
                    r_tgt_old_key <= r_rd_q.key;
                end else begin
                    r_tgt         <= r_victim;
                    r_tgt_old_key <= r_victim_key;
                end
            end
        end

        if (wr_fire) begin
            r_out_slot    <= SLOT_OUT_W'(r_tgt);
            r_out_hit     <= r_tgt_hit;
            r_out_evicted <= r_tgt_evict;
            r_out_old_key <= r_tgt_old_key;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_slot      = r_out_slot;
    assign o_hit       = r_out_hit;
    assign o_evicted   = r_out_evicted;
    assign o_old_key   = r_out_old_key;

endmodule

// File: rtl/gcsl_checker.sv
// ----------------------------------------------------------------------------
// gcsl_checker
// Port-level checks for the glyph cache slot lookup block.
// ----------------------------------------------------------------------------
module gcsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [9:0]  o_slot,
    input logic        o_hit,
    input logic        o_evicted,
    input logic [20:0] o_old_key
);

    // reset starts the clearing pass, so input is held off
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // input is taken only in the idle state: no two input beats in a row
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    // a hit never replaces anything
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (!o_evicted && o_old_key == 21'd0))
        else $error("hit reported with eviction");

    // old key only on an eviction
    a_old_key_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted) |-> (o_old_key == 21'd0))
        else $error("old key without eviction");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_slot)
            && $stable(o_hit) && $stable(o_evicted) && $stable(o_old_key)))
        else $error("stalled result changed");

endmodule

bind glyph_cache_slot_lookup_core gcsl_checker u_gcsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_slot      (o_slot),
    .o_hit       (o_hit),
    .o_evicted   (o_evicted),
    .o_old_key   (o_old_key)
);
